@@ rtl/core/jsme_pkg.sv @@
// ----------------------------------------------------------------------------
// jsme_pkg
// Shared types, sizes and codes for the job-shop makespan evaluator.
// ----------------------------------------------------------------------------
package jsme_pkg;

  localparam int unsigned MaxJobs      = 16;
  localparam int unsigned MaxMachines  = 16;
  localparam int unsigned DurationBits = 16;
  localparam int unsigned TimeBits     = 24;

  localparam int unsigned JobBits  = $clog2(MaxJobs);
  localparam int unsigned MachBits = $clog2(MaxMachines);
  localparam int unsigned CellBits = JobBits + MachBits;
  localparam int unsigned Cells    = MaxJobs * MaxMachines;
  localparam int unsigned JCntBits = $clog2(MaxJobs + 1);
  localparam int unsigned MCntBits = $clog2(MaxMachines + 1);
  localparam int unsigned DoneBits = $clog2(Cells + 1);

  typedef enum logic [1:0] {
    CmdLoadOp    = 2'd0,
    CmdLoadOrder = 2'd1,
    CmdEvaluate  = 2'd2,
    CmdRead      = 2'd3
  } cmd_e;

  localparam logic CfgJobCount     = 1'b0;
  localparam logic CfgMachineCount = 1'b1;

  typedef struct packed {
    logic [1:0]  command;
    logic [3:0]  job_index;
    logic [3:0]  op_index;
    logic [3:0]  machine_index;
    logic [3:0]  position;
    logic [15:0] duration;
  } in_item_t;

  typedef struct packed {
    logic        result_kind;
    logic [23:0] makespan_value;
    logic        feasible;
    logic [3:0]  scheduled_job;
    logic [23:0] start_time;
    logic [23:0] end_time;
  } out_item_t;

  typedef enum logic [3:0] {
    StIdle,
    StReadWait,
    StReadOut,
    StEvInit,
    StEvVisit,
    StEvSearch,
    StEvCheck,
    StEvPlace,
    StEvMax,
    StEvOut,
    StHold
  } state_e;

  typedef struct packed {
    logic do_load;
    logic rd_issue;
    logic rd_capture;
    logic ev_init;
    logic visit;
    logic search;
    logic place;
    logic max_step;
    logic ev_capture;
    logic skip;
  } ctrl_t;

  typedef struct packed {
    logic all_done;
    logic deadlock;
    logic visit_ok;
    logic search_hit;
    logic search_end;
    logic place_ok;
    logic max_end;
  } stat_t;

endpackage

@@ rtl/core/jsme_ram.sv @@
// ----------------------------------------------------------------------------
// jsme_ram
// Single-port-write, single-port-read RAM with registered read data.
// ----------------------------------------------------------------------------
module jsme_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

@@ rtl/core/jsme_datapath.sv @@
// ----------------------------------------------------------------------------
// jsme_datapath
// Instance stores, progress registers and the scheduling arithmetic.
// ----------------------------------------------------------------------------
module jsme_datapath (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  jsme_pkg::in_item_t in_i,
  input  jsme_pkg::ctrl_t    ctrl_i,
  input  logic [4:0]         job_count_i,
  input  logic [4:0]         machine_count_i,
  output jsme_pkg::stat_t    stat_o,
  output jsme_pkg::out_item_t out_o
);

  localparam int unsigned JB = jsme_pkg::JobBits;
  localparam int unsigned MB = jsme_pkg::MachBits;
  localparam int unsigned CB = jsme_pkg::CellBits;
  localparam int unsigned TB = jsme_pkg::TimeBits;
  localparam int unsigned DB = jsme_pkg::DurationBits;
  localparam int unsigned JC = jsme_pkg::JCntBits;
  localparam int unsigned MC = jsme_pkg::MCntBits;
  localparam int unsigned NB = jsme_pkg::DoneBits;
  localparam logic [TB-1:0] TimeMax = {TB{1'b1}};

  logic [JC-1:0] nj;
  logic [MC-1:0] nm;
  always_comb begin
    nj = (job_count_i == 5'd0) ? JC'(1) :
         ({27'd0, job_count_i} > jsme_pkg::MaxJobs) ? JC'(jsme_pkg::MaxJobs) :
         JC'(job_count_i);
    nm = (machine_count_i == 5'd0) ? MC'(1) :
         ({27'd0, machine_count_i} > jsme_pkg::MaxMachines) ?
         MC'(jsme_pkg::MaxMachines) : MC'(machine_count_i);
  end

  logic [MB-1:0] m_q, m_d;
  logic [MC-1:0] fails_q, fails_d;
  logic [NB-1:0] done_q, done_d;
  logic [MC-1:0] p_q, p_d;
  logic [JB-1:0] j_q, j_d;
  logic [JB-1:0] mx_q, mx_d;
  logic [TB-1:0] best_q, best_d;
  logic [MC-1:0] next_op_q [jsme_pkg::MaxJobs];
  logic [TB-1:0] ready_q [jsme_pkg::MaxJobs];
  logic [JC-1:0] next_slot_q [jsme_pkg::MaxMachines];
  logic [TB-1:0] mfree_q [jsme_pkg::MaxMachines];
  logic [CB-1:0] rd_addr_q;
  jsme_pkg::out_item_t out_q;

  logic [JB-1:0] slot;
  logic          slot_ok;
  assign slot    = next_slot_q[m_q][JB-1:0];
  assign slot_ok = next_slot_q[m_q] < nj;

  // order store
  logic          ord_we;
  logic [CB-1:0] ord_wa, ord_ra;
  logic [JB-1:0] ord_rd;
  assign ord_we = ctrl_i.do_load && (in_i.command == jsme_pkg::CmdLoadOrder);
  assign ord_wa = {in_i.machine_index[MB-1:0], in_i.position[JB-1:0]};
  assign ord_ra = {m_q, slot};
  jsme_ram #(.Width(JB), .Depth(jsme_pkg::Cells)) u_order (
    .clk_i, .we_i(ord_we), .waddr_i(ord_wa), .wdata_i(in_i.job_index[JB-1:0]),
    .raddr_i(ord_ra), .rdata_o(ord_rd)
  );

  // routing store: machine and duration together
  logic          rt_we;
  logic [CB-1:0] rt_wa, rt_ra;
  logic [MB+DB-1:0] rt_rd;
  assign rt_we = ctrl_i.do_load && (in_i.command == jsme_pkg::CmdLoadOp);
  assign rt_wa = {in_i.job_index[JB-1:0], in_i.op_index[MB-1:0]};
  assign rt_ra = ctrl_i.visit ? {ord_rd, {MB{1'b0}}} : {j_q, p_d[MB-1:0]};
  jsme_ram #(.Width(MB + DB), .Depth(jsme_pkg::Cells)) u_route (
    .clk_i, .we_i(rt_we), .waddr_i(rt_wa),
    .wdata_i({in_i.machine_index[MB-1:0], in_i.duration[DB-1:0]}),
    .raddr_i(rt_ra), .rdata_o(rt_rd)
  );

  // schedule store
  logic [TB-1:0] start_t, end_t;
  logic [TB:0]   sum;
  logic [CB-1:0] sch_ra;
  logic [JB+2*TB-1:0] sch_rd;
  always_comb begin
    start_t = (slot != '0 && mfree_q[m_q] > ready_q[j_q]) ? mfree_q[m_q] : ready_q[j_q];
    sum     = {1'b0, start_t} + (TB + 1)'(rt_rd[DB-1:0]);
    end_t   = sum[TB] ? TimeMax : sum[TB-1:0];
  end
  assign sch_ra = rd_addr_q;
  jsme_ram #(.Width(JB + 2 * TB), .Depth(jsme_pkg::Cells)) u_sched (
    .clk_i, .we_i(ctrl_i.place), .waddr_i({m_q, slot}),
    .wdata_i({j_q, start_t, end_t}), .raddr_i(sch_ra), .rdata_o(sch_rd)
  );

  always_comb begin
    m_d = m_q; fails_d = fails_q; done_d = done_q; p_d = p_q; j_d = j_q;
    mx_d = mx_q; best_d = best_q;
    if (ctrl_i.ev_init) begin
      m_d = '0; fails_d = '0; done_d = '0; mx_d = '0; best_d = '0;
    end
    if (ctrl_i.visit) begin
      j_d = ord_rd; p_d = '0;
    end
    if (ctrl_i.search) begin
      p_d = p_q + MC'(1);
    end
    if (ctrl_i.skip) begin
      fails_d = fails_q + MC'(1);
      m_d = ({1'b0, m_q} + (MB + 1)'(1) >= (MB + 1)'(nm)) ? '0 : m_q + MB'(1);
    end
    if (ctrl_i.place) begin
      fails_d = '0; done_d = done_q + NB'(1);
    end
    if (ctrl_i.max_step) begin
      if (ready_q[mx_q] > best_q) best_d = ready_q[mx_q];
      mx_d = mx_q + JB'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_q <= '0; fails_q <= '0; done_q <= '0; p_q <= '0; j_q <= '0;
      mx_q <= '0; best_q <= '0;
      for (int i = 0; i < jsme_pkg::MaxJobs; i++) begin
        next_op_q[i] <= '0; ready_q[i] <= '0;
      end
      for (int i = 0; i < jsme_pkg::MaxMachines; i++) begin
        next_slot_q[i] <= '0; mfree_q[i] <= '0;
      end
    end else begin
      m_q <= m_d; fails_q <= fails_d; done_q <= done_d; p_q <= p_d; j_q <= j_d;
      mx_q <= mx_d; best_q <= best_d;
      if (ctrl_i.ev_init) begin
        for (int i = 0; i < jsme_pkg::MaxJobs; i++) begin
          next_op_q[i] <= '0; ready_q[i] <= '0;
        end
        for (int i = 0; i < jsme_pkg::MaxMachines; i++) begin
          next_slot_q[i] <= '0;
        end
      end
      if (ctrl_i.place) begin
        next_op_q[j_q] <= next_op_q[j_q] + MC'(1);
        ready_q[j_q] <= end_t;
        next_slot_q[m_q] <= next_slot_q[m_q] + JC'(1);
        mfree_q[m_q] <= end_t;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.rd_issue) begin
      rd_addr_q <= {in_i.machine_index[MB-1:0], in_i.position[JB-1:0]};
    end
    if (ctrl_i.rd_capture) begin
      out_q <= {1'b1, 24'd0, 1'b0, 4'(sch_rd[JB+2*TB-1:2*TB]),
                24'(sch_rd[2*TB-1:TB]), 24'(sch_rd[TB-1:0])};
    end
    if (ctrl_i.ev_capture) begin
      out_q <= {1'b0, stat_o.deadlock ? 24'd0 : 24'(best_q), !stat_o.deadlock,
                4'd0, 24'd0, 24'd0};
    end
  end

  assign stat_o.all_done   = done_q >= NB'(nj) * NB'(nm);
  assign stat_o.deadlock   = fails_q >= nm;
  assign stat_o.visit_ok   = slot_ok && ({1'b0, ord_rd} < (JB + 1)'(nj));
  assign stat_o.search_hit = rt_rd[MB+DB-1:DB] == m_q;
  assign stat_o.search_end = p_q + MC'(1) >= nm;
  assign stat_o.place_ok   = next_op_q[j_q] == p_q;
  assign stat_o.max_end    = {1'b0, mx_q} + (JB + 1)'(1) >= (JB + 1)'(nj);
  assign out_o = out_q;

endmodule

@@ rtl/core/jsme_ctrl.sv @@
// ----------------------------------------------------------------------------
// jsme_ctrl
// Command sequencer: loads, reads and the round-robin evaluation loop.
// ----------------------------------------------------------------------------
module jsme_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  input  logic [1:0]       command_i,
  input  logic             out_ready_i,
  input  jsme_pkg::stat_t  stat_i,
  output logic             in_ready_o,
  output logic             out_valid_o,
  output jsme_pkg::ctrl_t  ctrl_o
);

  jsme_pkg::state_e state_q, state_d;
  logic acc;

  assign in_ready_o  = (state_q == jsme_pkg::StIdle) ||
                       (state_q == jsme_pkg::StHold && out_ready_i);
  assign out_valid_o = state_q == jsme_pkg::StHold;
  assign acc         = in_valid_i && in_ready_o;

  always_comb begin
    state_d = state_q;
    case (state_q)
      jsme_pkg::StIdle, jsme_pkg::StHold: begin
        if (state_q == jsme_pkg::StHold && out_ready_i) state_d = jsme_pkg::StIdle;
        if (acc) begin
          case (command_i)
            jsme_pkg::CmdEvaluate: state_d = jsme_pkg::StEvInit;
            jsme_pkg::CmdRead:     state_d = jsme_pkg::StReadWait;
            default:               state_d = jsme_pkg::StIdle;
          endcase
        end
      end
      jsme_pkg::StReadWait: state_d = jsme_pkg::StReadOut;
      jsme_pkg::StReadOut:  state_d = jsme_pkg::StHold;
      jsme_pkg::StEvInit:   state_d = jsme_pkg::StEvVisit;
      jsme_pkg::StEvVisit: begin
        if (stat_i.all_done || stat_i.deadlock) state_d = jsme_pkg::StEvMax;
        else state_d = jsme_pkg::StEvSearch;
      end
      jsme_pkg::StEvSearch: begin
        if (!stat_i.visit_ok) state_d = jsme_pkg::StEvVisit;
        else state_d = jsme_pkg::StEvCheck;
      end
      jsme_pkg::StEvCheck: begin
        if (stat_i.search_hit) begin
          state_d = stat_i.place_ok ? jsme_pkg::StEvPlace : jsme_pkg::StEvVisit;
        end else if (stat_i.search_end) state_d = jsme_pkg::StEvVisit;
      end
      jsme_pkg::StEvPlace: state_d = jsme_pkg::StEvVisit;
      jsme_pkg::StEvMax: begin
        if (stat_i.deadlock || stat_i.max_end) state_d = jsme_pkg::StEvOut;
      end
      jsme_pkg::StEvOut: state_d = jsme_pkg::StHold;
      default: state_d = jsme_pkg::StIdle;
    endcase
  end

  // StEvVisit waits the order read; StEvSearch latches the job and reads op 0
  always_comb begin
    ctrl_o = '0;
    ctrl_o.do_load  = acc;
    ctrl_o.rd_issue = acc && command_i == jsme_pkg::CmdRead;
    case (state_q)
      jsme_pkg::StReadOut: ctrl_o.rd_capture = 1'b1;
      jsme_pkg::StEvInit:  ctrl_o.ev_init = 1'b1;
      jsme_pkg::StEvSearch: begin
        if (stat_i.visit_ok) ctrl_o.visit = 1'b1;
        else ctrl_o.skip = 1'b1;
      end
      jsme_pkg::StEvCheck: begin
        if (stat_i.search_hit) begin
          if (stat_i.place_ok) ctrl_o.place = 1'b1;
          else ctrl_o.skip = 1'b1;
        end else if (stat_i.search_end) ctrl_o.skip = 1'b1;
        else ctrl_o.search = 1'b1;
      end
      jsme_pkg::StEvMax: begin
        if (!stat_i.deadlock) ctrl_o.max_step = 1'b1;
      end
      jsme_pkg::StEvOut: ctrl_o.ev_capture = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= jsme_pkg::StIdle;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

@@ rtl/core/job_shop_makespan_evaluator_top.sv @@
// Load beats give no result; a read result passes the address register, the store's read
// register and the output register. Evaluate: StEvVisit and StEvSearch per visit, StEvCheck
// per routing step tried, StEvPlace per placed operation, then StEvMax over the jobs for the
// makespan (left at once on deadlock) and StEvOut; the search over the routing store is serial.
// Throughput: one beat at a time; the next beat is taken as the result leaves.
// Reset: asynchronous active low; counts go to 1, progress clears, stores stay.
// ----------------------------------------------------------------------------
// job_shop_makespan_evaluator_top
// Job-shop semi-active schedule evaluator with schedule readback.
// ----------------------------------------------------------------------------
module job_shop_makespan_evaluator_top (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  jsme_pkg::in_item_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output jsme_pkg::out_item_t out_data_o,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [0:0]          cfg_index_i,
  input  logic [4:0]          cfg_data_i
);

  logic [4:0] job_count_q, machine_count_q;
  jsme_pkg::ctrl_t ctrl;
  jsme_pkg::stat_t stat;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      job_count_q <= 5'd1;
      machine_count_q <= 5'd1;
    end else if (cfg_valid_i) begin
      if (cfg_index_i == jsme_pkg::CfgJobCount) job_count_q <= cfg_data_i;
      else machine_count_q <= cfg_data_i;
    end
  end

  jsme_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid_i, .command_i(in_data_i.command), .out_ready_i,
    .stat_i(stat), .in_ready_o, .out_valid_o, .ctrl_o(ctrl)
  );

  jsme_datapath u_dp (
    .clk_i, .rst_ni, .in_i(in_data_i), .ctrl_i(ctrl), .job_count_i(job_count_q),
    .machine_count_i(machine_count_q), .stat_o(stat), .out_o(out_data_o)
  );

`ifndef SYNTHESIS
  a_no_load_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl.place |-> !in_ready_o) else $error("place while accepting");
  a_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl.rd_capture |=> out_valid_o && out_data_o.result_kind)
    else $error("read result kind");
  a_dead: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_data_o.result_kind && !out_data_o.feasible) |->
    out_data_o.makespan_value == 24'd0) else $error("infeasible makespan");
  a_dl_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl.ev_capture |=> out_data_o.feasible == !$past(stat.deadlock))
    else $error("feasible flag");
`endif

endmodule

@@ tb/sv/job_shop_makespan_evaluator_top_tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// job_shop_makespan_evaluator_top_tb
// Self-checking bench for the job-shop makespan evaluator. The first entry of
// the routing and order stores is loaded, then a directed table runs (extremes,
// deadlocks, readback). After that come random phases: count settings, mostly
// feasible instances built from a random dispatch, some corrupted ones, evaluates
// and slot reads. Results are checked against a schedule predictor or typed row values.
// ----------------------------------------------------------------------------
module job_shop_makespan_evaluator_top_tb;

  localparam int unsigned RandItems = 820;

  typedef struct {
    jsme_pkg::in_item_t  item;
    bit                  typed;
    jsme_pkg::out_item_t want;
  } row_t;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_ready;
  jsme_pkg::in_item_t  in_data = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  jsme_pkg::out_item_t out_data;
  logic                cfg_valid = 1'b0;
  logic                cfg_ready;
  logic                cfg_index = jsme_pkg::CfgJobCount;
  logic [4:0]          cfg_data = '0;

  // predictor state
  logic [3:0]  rt_mach [jsme_pkg::Cells];
  logic [15:0] rt_dur  [jsme_pkg::Cells];
  logic [3:0]  ord_job [jsme_pkg::Cells];
  logic [3:0]  sl_job  [jsme_pkg::Cells];
  int unsigned sl_start[jsme_pkg::Cells];
  int unsigned sl_end  [jsme_pkg::Cells];
  bit          sl_written[jsme_pkg::Cells];
  int unsigned job_next[jsme_pkg::MaxJobs];
  int unsigned job_ready[jsme_pkg::MaxJobs];
  int unsigned mach_slot[jsme_pkg::MaxMachines];
  logic [4:0]  jobs_reg = 5'd1;
  logic [4:0]  machs_reg = 5'd1;

  jsme_pkg::out_item_t expected_results[$];
  int unsigned mismatches = 0;
  int unsigned beats_sent = 0;
  bit          no_idle = 1'b0;
  int unsigned stall_left = 0;

  job_shop_makespan_evaluator_top dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_data),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  always #5 clk = ~clk;

  initial begin
    #200_000_000;
    $display("TB_ERROR");
    $finish;
  end

  function automatic int unsigned eff_count(logic [4:0] v, int unsigned max);
    if (v == 0) return 1;
    return (v > max) ? max : v;
  endfunction

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (no_idle || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(4, 25);
  endfunction

  function automatic bit run_schedule(int unsigned nj, int unsigned nm);
    int unsigned done, total, fails, m, slot, cidx, j, p, st, en;
    bit placed;
    done = 0; total = nj * nm; fails = 0; m = 0;
    for (int i = 0; i < jsme_pkg::MaxJobs; i++) begin
      job_next[i] = 0;
      job_ready[i] = 0;
    end
    for (int i = 0; i < jsme_pkg::MaxMachines; i++) mach_slot[i] = 0;
    while (done < total) begin
      placed = 1'b0;
      if (fails >= nm) return 1'b0;
      slot = mach_slot[m];
      if (slot < nj) begin
        cidx = m * jsme_pkg::MaxJobs + slot;
        j = ord_job[cidx];
        if (j < nj) begin
          for (p = 0; p < nm; p++) if (rt_mach[j * jsme_pkg::MaxMachines + p] == m) break;
          if (p < nm && job_next[j] == p) begin
            st = job_ready[j];
            if (slot > 0 && sl_end[cidx - 1] > st) st = sl_end[cidx - 1];
            en = st + rt_dur[j * jsme_pkg::MaxMachines + p];
            if (en > 32'hFF_FFFF) en = 32'hFF_FFFF;
            sl_job[cidx] = 4'(j);
            sl_start[cidx] = st;
            sl_end[cidx] = en;
            sl_written[cidx] = 1'b1;
            job_ready[j] = en;
            job_next[j]++;
            mach_slot[m]++;
            done++;
            fails = 0;
            placed = 1'b1;
          end
        end
      end
      if (!placed) begin
        fails++;
        m = (m + 1) % nm;
      end
    end
    return 1'b1;
  endfunction

  task automatic schedule_step(input jsme_pkg::in_item_t it);
    jsme_pkg::out_item_t r;
    int unsigned nj, nm, best, cidx;
    r = '0;
    case (it.command)
      jsme_pkg::CmdLoadOp: begin
        rt_mach[it.job_index * jsme_pkg::MaxMachines + it.op_index] = it.machine_index;
        rt_dur[it.job_index * jsme_pkg::MaxMachines + it.op_index] = it.duration;
      end
      jsme_pkg::CmdLoadOrder:
        ord_job[it.machine_index * jsme_pkg::MaxJobs + it.position] = it.job_index;
      jsme_pkg::CmdEvaluate: begin
        nj = eff_count(jobs_reg, jsme_pkg::MaxJobs);
        nm = eff_count(machs_reg, jsme_pkg::MaxMachines);
        if (run_schedule(nj, nm)) begin
          best = 0;
          for (int j = 0; j < nj; j++) if (job_ready[j] > best) best = job_ready[j];
          r.makespan_value = best[23:0];
          r.feasible = 1'b1;
        end
        expected_results.push_back(r);
      end
      default: begin
        cidx = it.machine_index * jsme_pkg::MaxJobs + it.position;
        r.result_kind = 1'b1;
        r.scheduled_job = sl_job[cidx];
        r.start_time = sl_start[cidx][23:0];
        r.end_time = sl_end[cidx][23:0];
        expected_results.push_back(r);
      end
    endcase
  endtask

  // call at a rising edge; returns at a rising edge
  task automatic send(input jsme_pkg::in_item_t it, input bit typed = 1'b0,
                      input jsme_pkg::out_item_t want = '0);
    int unsigned gap;
    in_data <= it;
    in_valid <= 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    schedule_step(it);
    if (typed) expected_results[expected_results.size() - 1] = want;
    beats_sent++;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (expected_results.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic write_reg(input logic idx, input logic [4:0] val);
    cfg_index <= idx;
    cfg_data <= val;
    cfg_valid <= 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    if (idx == jsme_pkg::CfgJobCount) jobs_reg = val;
    else machs_reg = val;
    @(posedge clk);
  endtask

  function automatic jsme_pkg::in_item_t mk(jsme_pkg::cmd_e c, int unsigned j,
                                            int unsigned o, int unsigned m,
                                            int unsigned p, int unsigned d);
    jsme_pkg::in_item_t it;
    it.command = c;
    it.job_index = 4'(j);
    it.op_index = 4'(o);
    it.machine_index = 4'(m);
    it.position = 4'(p);
    it.duration = 16'(d);
    return it;
  endfunction

  function automatic jsme_pkg::out_item_t ev_res(int unsigned ms, bit ok);
    jsme_pkg::out_item_t r;
    r = '0;
    r.makespan_value = 24'(ms);
    r.feasible = ok;
    return r;
  endfunction

  function automatic int unsigned pick_dur();
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r == 0) return 16'hFFFF;
    if (r == 1) return 0;
    if (r < 4) return $urandom_range(0, 16'hFFFF);
    return $urandom_range(1, 40);
  endfunction

  function automatic logic [4:0] pick_count();
    int unsigned r;
    r = $urandom_range(0, 19);
    if (r == 0) return 5'd0;
    if (r == 1) return 5'd31;
    if (r == 2) return 5'd16;
    if (r == 3) return 5'd1;
    return 5'($urandom_range(2, 5));
  endfunction

  // checker and receiver stalls
  always @(posedge clk) begin
    if (out_valid && out_ready) begin
      if (expected_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result beat %p", out_data);
      end else begin
        if (out_data.result_kind !== expected_results[0].result_kind ||
            out_data.makespan_value !== expected_results[0].makespan_value ||
            out_data.feasible !== expected_results[0].feasible ||
            out_data.scheduled_job !== expected_results[0].scheduled_job ||
            out_data.start_time !== expected_results[0].start_time ||
            out_data.end_time !== expected_results[0].end_time) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected %p actual %p", expected_results[0], out_data);
        end
        void'(expected_results.pop_front());
      end
    end
    if (stall_left > 0) begin
      out_ready <= 1'b0;
      stall_left <= stall_left - 1;
    end else begin
      out_ready <= 1'b1;
      if (!no_idle && $urandom_range(0, 3) == 0)
        stall_left <= ($urandom_range(0, 9) == 0) ? $urandom_range(5, 30)
                                                   : $urandom_range(1, 3);
    end
  end

  initial begin
    row_t table_rows[$];
    row_t rw;
    int unsigned nj, nm, goal, cnt, tries, cidx;
    int unsigned rtp[jsme_pkg::MaxJobs][jsme_pkg::MaxMachines];
    int unsigned nx[jsme_pkg::MaxJobs];
    int unsigned ms[jsme_pkg::MaxMachines];
    int unsigned cand[$];
    int unsigned tmp, k, j, m;
    jsme_pkg::out_item_t got;

    for (int i = 0; i < jsme_pkg::Cells; i++) sl_written[i] = 1'b0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // load the entries that the single-job, single-machine rows use
    send(mk(jsme_pkg::CmdLoadOp, 0, 0, 0, 0, 0));
    send(mk(jsme_pkg::CmdLoadOrder, 0, 0, 0, 0, 0));
    drain();

    rw.typed = 1'b1; rw.item = mk(jsme_pkg::CmdEvaluate, 0, 0, 0, 0, 0);
    rw.want = ev_res(0, 1);
    table_rows.push_back(rw);
    got = '0; got.result_kind = 1'b1;
    rw.item = mk(jsme_pkg::CmdRead, 0, 0, 0, 0, 0); rw.want = got;
    table_rows.push_back(rw);
    rw.typed = 1'b0; rw.item = mk(jsme_pkg::CmdLoadOp, 0, 0, 0, 0, 16'hFFFF);
    table_rows.push_back(rw);
    rw.typed = 1'b1; rw.item = mk(jsme_pkg::CmdEvaluate, 0, 0, 0, 0, 0);
    rw.want = ev_res(16'hFFFF, 1);
    table_rows.push_back(rw);
    got.end_time = 24'h00FFFF;
    rw.item = mk(jsme_pkg::CmdRead, 0, 0, 0, 0, 0); rw.want = got;
    table_rows.push_back(rw);
    rw.typed = 1'b0; rw.item = mk(jsme_pkg::CmdLoadOp, 0, 0, 15, 0, 7);
    table_rows.push_back(rw);
    rw.typed = 1'b1; rw.item = mk(jsme_pkg::CmdEvaluate, 0, 0, 0, 0, 0);
    rw.want = ev_res(0, 0);
    table_rows.push_back(rw);
    rw.typed = 1'b0; rw.item = mk(jsme_pkg::CmdRead, 0, 0, 0, 0, 0);
    table_rows.push_back(rw);
    rw.item = mk(jsme_pkg::CmdLoadOp, 0, 0, 0, 0, 3);
    table_rows.push_back(rw);
    rw.item = mk(jsme_pkg::CmdLoadOrder, 15, 0, 0, 0, 0);
    table_rows.push_back(rw);
    rw.typed = 1'b1; rw.item = mk(jsme_pkg::CmdEvaluate, 0, 0, 0, 0, 0);
    rw.want = ev_res(0, 0);
    table_rows.push_back(rw);
    rw.typed = 1'b0; rw.item = mk(jsme_pkg::CmdLoadOrder, 0, 0, 0, 0, 0);
    table_rows.push_back(rw);
    rw.item = mk(jsme_pkg::CmdLoadOp, 15, 15, 15, 0, 16'hFFFF);
    table_rows.push_back(rw);
    rw.item = mk(jsme_pkg::CmdLoadOrder, 15, 0, 15, 15, 0);
    table_rows.push_back(rw);
    rw.item = mk(jsme_pkg::CmdEvaluate, 0, 0, 0, 0, 0);
    table_rows.push_back(rw);
    rw.item = mk(jsme_pkg::CmdRead, 0, 0, 0, 0, 0);
    table_rows.push_back(rw);

    foreach (table_rows[i]) begin
      send(table_rows[i].item, table_rows[i].typed, table_rows[i].want);
    end
    drain();

    goal = beats_sent + RandItems;
    while (beats_sent < goal) begin
      no_idle = ($urandom_range(0, 4) == 0);
      write_reg(jsme_pkg::CfgJobCount, pick_count());
      write_reg(jsme_pkg::CfgMachineCount, pick_count());
      nj = eff_count(jobs_reg, jsme_pkg::MaxJobs);
      nm = eff_count(machs_reg, jsme_pkg::MaxMachines);
      @(posedge clk);

      // random routing permutations and a dispatch that yields feasible orders
      for (j = 0; j < nj; j++) begin
        for (k = 0; k < nm; k++) rtp[j][k] = k;
        for (k = nm - 1; k > 0; k--) begin
          m = $urandom_range(0, k);
          tmp = rtp[j][k]; rtp[j][k] = rtp[j][m]; rtp[j][m] = tmp;
        end
        for (k = 0; k < nm; k++)
          send(mk(jsme_pkg::CmdLoadOp, j, k, rtp[j][k], 0, pick_dur()));
        nx[j] = 0;
      end
      for (m = 0; m < nm; m++) ms[m] = 0;
      for (cnt = 0; cnt < nj * nm; cnt++) begin
        cand.delete();
        for (j = 0; j < nj; j++) if (nx[j] < nm) cand.push_back(j);
        j = cand[$urandom_range(0, cand.size() - 1)];
        m = rtp[j][nx[j]];
        send(mk(jsme_pkg::CmdLoadOrder, j, 0, m, ms[m], 0));
        ms[m]++;
        nx[j]++;
      end
      // corrupt some instances
      if ($urandom_range(0, 3) == 0) begin
        if ($urandom_range(0, 1) == 0)
          send(mk(jsme_pkg::CmdLoadOp, $urandom_range(0, nj - 1), $urandom_range(0, nm - 1),
                  $urandom_range(0, 15), 0, pick_dur()));
        else
          send(mk(jsme_pkg::CmdLoadOrder, $urandom_range(0, 15), 0,
                  $urandom_range(0, nm - 1), $urandom_range(0, nj - 1), 0));
      end
      send(mk(jsme_pkg::CmdEvaluate, $urandom, $urandom, $urandom, $urandom, $urandom));
      for (cnt = 0; cnt < 3; cnt++) begin
        for (tries = 0; tries < 20; tries++) begin
          if ($urandom_range(0, 3) == 0) cidx = $urandom_range(0, jsme_pkg::Cells - 1);
          else cidx = $urandom_range(0, nm - 1) * jsme_pkg::MaxJobs + $urandom_range(0, nj - 1);
          if (sl_written[cidx]) break;
        end
        if (sl_written[cidx])
          send(mk(jsme_pkg::CmdRead, $urandom, $urandom, cidx / jsme_pkg::MaxJobs,
                  cidx % jsme_pkg::MaxJobs, $urandom));
      end
      if ($urandom_range(0, 2) == 0)
        send(mk(jsme_pkg::CmdEvaluate, $urandom, $urandom, $urandom, $urandom, $urandom));
      drain();
    end

    no_idle = 1'b0;
    drain();
    if (mismatches == 0 && expected_results.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
rtl/core/jsme_pkg.sv
rtl/core/jsme_ram.sv
rtl/core/jsme_datapath.sv
rtl/core/jsme_ctrl.sv
rtl/core/job_shop_makespan_evaluator_top.sv
tb/sv/job_shop_makespan_evaluator_top_tb.sv
